// ----- rtl/core/mbrf_pkg.sv -----
`timescale 1ns / 1ps
package mbrf_pkg;

  localparam int MAX_WORDS  = 123;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH = 2;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] ADDR_DFLT = 16'hFFFF;
  localparam logic [7:0]  DFLT_SLAVE_RST = 8'd1;

  typedef enum logic [1:0] {
    CMD_SINGLE = 2'd0,
    CMD_MULTI  = 2'd1,
    CMD_CONT   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        ends_frame;
    logic [7:0]  dest_addr;
    logic [7:0]  func;
    logic [15:0] reg_addr;
    logic [6:0]  count;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic       frame_open;
    logic [6:0] words_left;
  } front_stat_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/mbrf_front.sv -----
`timescale 1ns / 1ps
module mbrf_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [15:0]          in_slave_address,
  input  logic [7:0]           in_function_code,
  input  logic [15:0]          in_register_address,
  input  logic [6:0]           in_word_count,
  input  logic [15:0]          in_register_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_default_slave_address,
  input  logic                 q_full,
  output logic                 q_push,
  output mbrf_pkg::cmd_t       q_din,
  output mbrf_pkg::front_stat_t stat
);
  import mbrf_pkg::*;

  logic [7:0] dflt_r;
  logic       open_r, open_nxt;
  logic [6:0] left_r, left_nxt;
  logic [6:0] cnt_sat;
  logic [6:0] left_dec;
  cmd_t       cmd;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign q_push    = in_push && !q_full;
  assign q_din     = cmd;
  assign stat      = '{frame_open: open_r, words_left: left_r};

  always_comb begin
    cnt_sat  = (in_word_count > 7'(MAX_WORDS)) ? 7'(MAX_WORDS) : in_word_count;
    left_dec = left_r - 7'd1;
    cmd.dest_addr = (in_slave_address == ADDR_DFLT || in_slave_address[15:8] != 8'h00)
                    ? dflt_r : in_slave_address[7:0];
    cmd.func     = in_function_code;
    cmd.reg_addr = in_register_address;
    cmd.count    = cnt_sat;
    cmd.value    = in_register_value;
    open_nxt     = open_r;
    left_nxt     = left_r;
    if (open_r) begin
      cmd.kind       = CMD_CONT;
      cmd.ends_frame = (left_dec == 7'd0);
      left_nxt       = left_dec;
      open_nxt       = (left_dec != 7'd0);
    end else if (cnt_sat == 7'd0) begin
      cmd.kind       = CMD_SINGLE;
      cmd.ends_frame = 1'b1;
    end else begin
      cmd.kind       = CMD_MULTI;
      cmd.ends_frame = (cnt_sat == 7'd1);
      left_nxt       = cnt_sat - 7'd1;
      open_nxt       = (cnt_sat != 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r <= DFLT_SLAVE_RST;
      open_r <= 1'b0;
      left_r <= 7'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dflt_r <= cfg_default_slave_address;
      end
      if (q_push) begin
        open_r <= open_nxt;
        left_r <= left_nxt;
      end
    end
  end

endmodule

// ----- rtl/core/mbrf_cmd_q.sv -----
`timescale 1ns / 1ps
module mbrf_cmd_q (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mbrf_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output mbrf_pkg::cmd_t dout,
  output logic           empty
);
  import mbrf_pkg::*;

  cmd_t               mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_AW:0]   cnt_r;

  assign full  = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/mbrf_back.sv -----
`timescale 1ns / 1ps
module mbrf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  mbrf_pkg::cmd_t q_dout,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_frame_byte,
  output logic           out_last_byte
);
  import mbrf_pkg::*;

  typedef enum logic [10:0] {
    ST_ADDR   = 11'b000_0000_0001,
    ST_FUNC   = 11'b000_0000_0010,
    ST_RA_HI  = 11'b000_0000_0100,
    ST_RA_LO  = 11'b000_0000_1000,
    ST_CNT_HI = 11'b000_0001_0000,
    ST_CNT_LO = 11'b000_0010_0000,
    ST_BCNT   = 11'b000_0100_0000,
    ST_V_HI   = 11'b000_1000_0000,
    ST_V_LO   = 11'b001_0000_0000,
    ST_CRC_LO = 11'b010_0000_0000,
    ST_CRC_HI = 11'b100_0000_0000
  } step_t;

  cmd_t        cmd_r;
  step_t       step_r, step_nxt;
  logic        active_r;
  logic [15:0] crc_r;
  logic        done;
  logic        emit;
  logic        room;
  logic [7:0]  byte_val;
  logic        byte_last;
  logic        crc_step;

  logic [7:0]         oq_byte [OUTQ_DEPTH];
  logic               oq_last [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] owr_r;
  logic [OUTQ_AW-1:0] ord_r;
  logic [OUTQ_AW:0]   ocnt_r;
  logic               opop;

  assign out_empty      = (ocnt_r == '0);
  assign opop           = out_pop && !out_empty;
  assign room           = (ocnt_r != (OUTQ_AW+1)'(OUTQ_DEPTH)) || opop;
  assign out_frame_byte = oq_byte[ord_r];
  assign out_last_byte  = oq_last[ord_r];

  assign emit      = active_r && room;
  assign q_pop     = !q_empty && (!active_r || (emit && done));
  assign byte_last = (step_r == ST_CRC_HI);
  assign crc_step  = (step_r == ST_CRC_LO) || (step_r == ST_CRC_HI);

  always_comb begin
    step_nxt = step_r;
    done     = 1'b0;
    byte_val = 8'h00;
    unique case (step_r)
      ST_ADDR: begin
        byte_val = cmd_r.dest_addr;
        step_nxt = ST_FUNC;
      end
      ST_FUNC: begin
        byte_val = cmd_r.func;
        step_nxt = ST_RA_HI;
      end
      ST_RA_HI: begin
        byte_val = cmd_r.reg_addr[15:8];
        step_nxt = ST_RA_LO;
      end
      ST_RA_LO: begin
        byte_val = cmd_r.reg_addr[7:0];
        step_nxt = (cmd_r.kind == CMD_SINGLE) ? ST_V_HI : ST_CNT_HI;
      end
      ST_CNT_HI: begin
        byte_val = 8'h00;
        step_nxt = ST_CNT_LO;
      end
      ST_CNT_LO: begin
        byte_val = {1'b0, cmd_r.count};
        step_nxt = ST_BCNT;
      end
      ST_BCNT: begin
        byte_val = {cmd_r.count, 1'b0};
        step_nxt = ST_V_HI;
      end
      ST_V_HI: begin
        byte_val = cmd_r.value[15:8];
        step_nxt = ST_V_LO;
      end
      ST_V_LO: begin
        byte_val = cmd_r.value[7:0];
        step_nxt = ST_CRC_LO;
        done     = !cmd_r.ends_frame;
      end
      ST_CRC_LO: begin
        byte_val = crc_r[7:0];
        step_nxt = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        byte_val = crc_r[15:8];
        done     = 1'b1;
      end
      default: begin
        byte_val = 8'h00;
        done     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= ST_ADDR;
      crc_r    <= CRC_INIT;
    end else begin
      if (emit && !crc_step) begin
        crc_r <= crc_update((step_r == ST_ADDR) ? CRC_INIT : crc_r, byte_val);
      end
      if (q_pop) begin
        active_r <= 1'b1;
        step_r   <= (q_dout.kind == CMD_CONT) ? ST_V_HI : ST_ADDR;
      end else if (emit) begin
        if (done) begin
          active_r <= 1'b0;
        end else begin
          step_r <= step_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_dout;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      oq_byte[owr_r] <= byte_val;
      oq_last[owr_r] <= byte_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (emit) begin
        owr_r <= owr_r + 1'b1;
      end
      if (opop) begin
        ord_r <= ord_r + 1'b1;
      end
      if (emit && !opop) begin
        ocnt_r <= ocnt_r + 1'b1;
      end else if (opop && !emit) begin
        ocnt_r <= ocnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/modbus_rtu_request_framer_top.sv -----
// Channel   Direction  Handshake             Payload
// in_*      input      in_push / in_full     slave_address, function_code, register_address,
//                                            word_count, register_value
// out_*     output     out_pop / out_empty   frame_byte, last_byte
// cfg_*     input      cfg_valid / cfg_ready default_slave_address
//
// The back sequencer emits one byte per cycle while the output queue has room: a continuation
// item gives 2 bytes, a first item 6 bytes (single value) or 9 bytes (word list), plus 2
// CRC bytes on the item that closes a frame.
// A 4-entry command queue lets the front take items while the back is still serializing.
// Reset is synchronous, active low; the default slave address resets to 1.
// With out_pop low the 2-entry output queue fills and the back holds; in_full rises once
// the command queue is full.
`timescale 1ns / 1ps
module modbus_rtu_request_framer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_slave_address,
  input  logic [7:0]  in_function_code,
  input  logic [15:0] in_register_address,
  input  logic [6:0]  in_word_count,
  input  logic [15:0] in_register_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_frame_byte,
  output logic        out_last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_default_slave_address
);
  import mbrf_pkg::*;

  cmd_t        q_din;
  cmd_t        q_dout;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;
  front_stat_t stat;

  mbrf_front u_front (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_push                   (in_push),
    .in_full                   (in_full),
    .in_slave_address          (in_slave_address),
    .in_function_code          (in_function_code),
    .in_register_address       (in_register_address),
    .in_word_count             (in_word_count),
    .in_register_value         (in_register_value),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_default_slave_address (cfg_default_slave_address),
    .q_full                    (q_full),
    .q_push                    (q_push),
    .q_din                     (q_din),
    .stat                      (stat)
  );

  mbrf_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  mbrf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_dout         (q_dout),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

`ifndef SYNTHESIS
  a_open_has_words: assert property (@(posedge clk) disable iff (!rst_n)
    stat.frame_open |-> stat.words_left != 7'd0)
    else $error("open frame with no words left");

  a_closed_no_words: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.frame_open |-> stat.words_left == 7'd0)
    else $error("closed frame with words left");

  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_empty)
    else $error("command queue full and empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full && in_push)
    else $error("command push while full");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import mbrf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    logic [15:0] slave_address;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [6:0]  word_count;
    logic [15:0] register_value;
  } request_t;

  class frame_byte_scoreboard;
    bit [15:0] crc;
    bit [6:0]  words_left;
    bit        open;
    bit [7:0]  default_addr;
    bit [8:0]  wire_bytes_q[$];
    int        mismatches;
    int        checked;
    int        frames;

    function new();
      crc          = CRC_INIT;
      words_left   = '0;
      open         = 1'b0;
      default_addr = DFLT_SLAVE_RST;
    endfunction

    function bit [15:0] crc_next(bit [15:0] c, bit [7:0] b);
      bit [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void emit(bit [7:0] b, bit last);
      wire_bytes_q.push_back({last, b});
      if (!last) crc = crc_next(crc, b);
    endfunction

    function void emit_word(bit [15:0] w);
      emit(w[15:8], 1'b0);
      emit(w[7:0], 1'b0);
    endfunction

    function void close_frame();
      bit [15:0] c;
      c = crc;
      emit(c[7:0], 1'b0);
      emit(c[15:8], 1'b1);
      crc        = CRC_INIT;
      words_left = '0;
      open       = 1'b0;
      frames++;
    endfunction

    function void take_request(request_t r);
      bit [6:0] cnt;
      bit [7:0] addr;
      if (!open) begin
        cnt  = (r.word_count > MAX_WORDS) ? 7'(MAX_WORDS) : r.word_count;
        addr = (r.slave_address > 16'h00FF) ? default_addr : r.slave_address[7:0];
        crc  = CRC_INIT;
        emit(addr, 1'b0);
        emit(r.function_code, 1'b0);
        emit_word(r.register_address);
        if (cnt == 0) begin
          emit_word(r.register_value);
          close_frame();
        end else begin
          emit_word({9'd0, cnt});
          emit({cnt, 1'b0}, 1'b0);
          emit_word(r.register_value);
          words_left = cnt - 7'd1;
          if (words_left == 0) close_frame();
          else open = 1'b1;
        end
      end else begin
        emit_word(r.register_value);
        if (words_left > 0) words_left--;
        if (words_left == 0) close_frame();
      end
    endfunction

    function void check_wire_byte(bit [7:0] b, bit last);
      bit [8:0] exp_byte;
      if (wire_bytes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected byte %02h last=%0b", $realtime, b, last);
        return;
      end
      exp_byte = wire_bytes_q.pop_front();
      checked++;
      if (exp_byte[7:0] !== b || exp_byte[8] !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] byte %0d: expected %02h last=%0b, got %02h last=%0b",
                   $realtime, checked, exp_byte[7:0], exp_byte[8], b, last);
      end
    endfunction

    function int pending();
      return wire_bytes_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_slave_address = '0;
  logic [7:0]  in_function_code = '0;
  logic [15:0] in_register_address = '0;
  logic [6:0]  in_word_count = '0;
  logic [15:0] in_register_value = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_frame_byte;
  logic        out_last_byte;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_default_slave_address = '0;

  frame_byte_scoreboard sb = new();
  bit idle_on = 1'b1;
  int cycle_count = 0;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;
  int n_items = 0;
  int n_cfg = 0;
  int full_hits = 0;

  always #2 clk = ~clk;

  modbus_rtu_request_framer_top dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_push                   (in_push),
    .in_full                   (in_full),
    .in_slave_address          (in_slave_address),
    .in_function_code          (in_function_code),
    .in_register_address       (in_register_address),
    .in_word_count             (in_word_count),
    .in_register_value         (in_register_value),
    .out_empty                 (out_empty),
    .out_pop                   (out_pop),
    .out_frame_byte            (out_frame_byte),
    .out_last_byte             (out_last_byte),
    .cfg_valid                 (cfg_valid),
    .cfg_ready                 (cfg_ready),
    .cfg_default_slave_address (cfg_default_slave_address)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) sb.check_wire_byte(out_frame_byte, out_last_byte);
      if (hold_left == 0 && hold_asks != hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = hold_asks;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= !(idle_on && $urandom_range(99) < 16);
      end
    end
  end

  task automatic send_req(input request_t r);
    if (idle_on && $urandom_range(99) < 16) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_push             <= 1'b1;
    in_slave_address    <= r.slave_address;
    in_function_code    <= r.function_code;
    in_register_address <= r.register_address;
    in_word_count       <= r.word_count;
    in_register_value   <= r.register_value;
    do begin
      @(posedge clk);
      if (in_full) full_hits++;
    end while (in_full);
    sb.take_request(r);
    n_items++;
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_default(input logic [7:0] v);
    drain();
    cfg_valid                 <= 1'b1;
    cfg_default_slave_address <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.default_addr = v;
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic send_first(input logic [15:0] sa, input logic [7:0] fc,
                            input logic [15:0] ra, input logic [6:0] cnt,
                            input logic [15:0] v);
    request_t r;
    r.slave_address    = sa;
    r.function_code    = fc;
    r.register_address = ra;
    r.word_count       = cnt;
    r.register_value   = v;
    send_req(r);
  endtask

  task automatic send_frame(input logic [15:0] sa, input logic [7:0] fc,
                            input logic [15:0] ra, input logic [6:0] cnt);
    request_t r;
    int       rest;
    send_first(sa, fc, ra, cnt, 16'($urandom));
    rest = (cnt > MAX_WORDS) ? MAX_WORDS - 1 : (cnt == 0 ? 0 : cnt - 1);
    repeat (rest) begin
      // continuation: only the value matters, so scramble the rest half the time
      if ($urandom_range(1)) begin
        r.slave_address    = 16'($urandom);
        r.function_code    = 8'($urandom);
        r.register_address = 16'($urandom);
        r.word_count       = 7'($urandom);
      end else begin
        r.slave_address    = '0;
        r.function_code    = '0;
        r.register_address = '0;
        r.word_count       = '0;
      end
      r.register_value = 16'($urandom);
      send_req(r);
    end
  endtask

  function automatic logic [15:0] pick_slave();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 16'($urandom_range(0, 255));
    if (p < 75) return ADDR_DFLT;
    if (p < 90) return 16'($urandom_range(256, 16'hFFFE));
    return 16'($urandom);
  endfunction

  function automatic logic [6:0] pick_count();
    int p;
    p = $urandom_range(99);
    if (p < 2) return 7'($urandom_range(64, 127));
    if (p < 32) return 7'd0;
    if (p < 88) return 7'($urandom_range(1, 4));
    return 7'($urandom_range(5, 12));
  endfunction

  task automatic random_frames(input int n);
    int stop_at;
    stop_at = n_items + n;
    while (n_items < stop_at)
      send_frame(pick_slave(), 8'($urandom), 16'($urandom), pick_count());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_first(16'h0011, 8'h03, 16'h0000, 7'd0, 16'h0000);
    send_first(16'h0000, 8'h00, 16'hFFFF, 7'd0, 16'hFFFF);
    send_first(16'h00FF, 8'hFF, 16'h1234, 7'd0, 16'hA5A5);
    send_first(16'h0100, 8'h06, 16'h0040, 7'd0, 16'h5A5A);
    send_first(ADDR_DFLT, 8'h06, 16'h8000, 7'd0, 16'h0001);
    send_first(16'hFF00, 8'h10, 16'h00FF, 7'd0, 16'h8000);
    send_first(16'h0001, 8'h10, 16'h0001, 7'd1, 16'hFFFF);
    send_first(16'h0022, 8'h10, 16'h0100, 7'd3, 16'h1111);
    send_first(ADDR_DFLT, 8'hFF, 16'hFFFF, 7'h7F, 16'h2222);
    send_first(16'h0000, 8'h00, 16'h0000, 7'd0, 16'h3333);
    send_first(ADDR_DFLT, 8'h10, 16'h4000, 7'd2, 16'h0000);
    send_first(16'h0300, 8'h00, 16'h0000, 7'd0, 16'hFFFF);

    write_default(8'h00);
    send_first(ADDR_DFLT, 8'h03, 16'h0002, 7'd0, 16'h00FF);
    send_first(16'h8000, 8'h10, 16'h0003, 7'd1, 16'hFF00);

    write_default(8'hFF);
    send_first(ADDR_DFLT, 8'h06, 16'hABCD, 7'd0, 16'h7FFF);
    send_first(16'h1FFF, 8'h10, 16'h0004, 7'd2, 16'h0F0F);
    send_first(16'h0000, 8'h00, 16'h0000, 7'd0, 16'hF0F0);

    write_default(8'($urandom_range(2, 254)));
    send_frame(ADDR_DFLT, 8'h10, 16'($urandom), 7'd127);
    random_frames(25);

    write_default(8'($urandom_range(1, 254)));
    hold_asks++;
    random_frames(45);

    write_default(8'h01);
    random_frames(25);
    drain();
    random_frames(20);

    write_default(8'($urandom_range(0, 255)));
    idle_on = 1'b0;
    random_frames(45);
    idle_on = 1'b1;
    random_frames(15);

    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests in %0d frames, checked %0d wire bytes", n_items, sb.frames,
             sb.checked);
    $display("Default address written %0d times, input stalled %0d cycles, %0d mismatches",
             n_cfg, full_hits, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/mbrf_pkg.sv
rtl/core/mbrf_front.sv
rtl/core/mbrf_cmd_q.sv
rtl/core/mbrf_back.sv
rtl/core/modbus_rtu_request_framer_top.sv
sim/tb.sv
